>>> hdl/dmchc_pkg.sv
// ----------------------------------------------------------------------------
// dmchc_pkg
// Shared types and constants for the direct-mapped cache hit counter.
// ----------------------------------------------------------------------------
package dmchc_pkg;

  localparam int LINES_LOG2_DEF = 10;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 48;
  localparam int BS_W    = 4;
  localparam int CS_W    = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE_LOG2 = 1'b1;

  localparam logic [BS_W-1:0] BS_RESET = 4'd3;
  localparam logic [CS_W-1:0] CS_RESET = 5'd12;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPARE
  } dmchc_state_t;

  typedef struct packed {
    logic lookup;
    logic clear;
    logic commit;
  } dmchc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_blocked;
  } dmchc_sts_t;

endpackage

>>> hdl/dmchc_ram.sv
// ----------------------------------------------------------------------------
// dmchc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmchc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/dmchc_ctrl.sv
// ----------------------------------------------------------------------------
// dmchc_ctrl
// Controller: sequences the valid-bit clearing pass and each lookup.
// ----------------------------------------------------------------------------
module dmchc_ctrl
  import dmchc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output dmchc_cmd_t cmd,
  input  dmchc_sts_t sts
);

  dmchc_state_t state_r;
  dmchc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.lookup = 1'b1;
          state_nxt  = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/dmchc_dp.sv
// ----------------------------------------------------------------------------
// dmchc_dp
// Datapath: geometry registers, index and tag extraction, tag and valid
// stores, hit compare, running counters and the result register.
// ----------------------------------------------------------------------------
module dmchc_dp
  import dmchc_pkg::*;
#(
  parameter int LINES_LOG2 = LINES_LOG2_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     in_access_address,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [COUNT_W-1:0]    out_hit_total,
  output logic [COUNT_W-1:0]    out_access_total,
  input  dmchc_cmd_t            cmd,
  output dmchc_sts_t            sts
);

  localparam int LINES = 1 << LINES_LOG2;
  localparam int AW    = (LINES > 1) ? LINES_LOG2 : 1;

  logic [BS_W-1:0]    bs_r, bs_nxt;
  logic [CS_W-1:0]    cs_r, cs_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [COUNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_W-1:0] acc_cnt_r, acc_cnt_nxt;

  logic [ADDR_W-1:0]  shifted;
  logic [CS_W-1:0]    span;
  logic [CS_W-1:0]    span_clamped;
  logic [AW-1:0]      idx_mask;
  logic [AW-1:0]      lookup_idx;
  logic [TAG_W-1:0]   lookup_tag;

  logic [TAG_W-1:0]   tag_q;
  logic               vld_q;
  logic               hit;
  logic               miss_we;
  logic               vld_we;
  logic [AW-1:0]      vld_waddr;
  logic               vld_wdata;

  always_comb begin
    shifted = in_access_address >> bs_r;
    if (cs_r > {1'b0, bs_r}) begin
      span = cs_r - {1'b0, bs_r};
    end else begin
      span = '0;
    end
    if (span > CS_W'(LINES_LOG2)) begin
      span_clamped = CS_W'(LINES_LOG2);
    end else begin
      span_clamped = span;
    end
    idx_mask   = ~({AW{1'b1}} << span_clamped);
    lookup_idx = shifted[AW-1:0] & idx_mask;
    lookup_tag = in_access_address >> cs_r;
  end

  assign hit     = vld_q && (tag_q == tag_r);
  assign miss_we = cmd.commit && !hit;

  always_comb begin
    if (cmd.clear) begin
      vld_we    = 1'b1;
      vld_waddr = clr_cnt_r;
      vld_wdata = 1'b0;
    end else begin
      vld_we    = miss_we;
      vld_waddr = idx_r;
      vld_wdata = 1'b1;
    end
  end

  dmchc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (miss_we),
    .waddr (idx_r),
    .wdata (tag_r),
    .re    (cmd.lookup),
    .raddr (lookup_idx),
    .rdata (tag_q)
  );

  dmchc_ram #(
    .WIDTH (1),
    .DEPTH (LINES)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (cmd.lookup),
    .raddr (lookup_idx),
    .rdata (vld_q)
  );

  always_comb begin
    bs_nxt        = bs_r;
    cs_nxt        = cs_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_nxt       = idx_r;
    tag_nxt       = tag_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    hit_cnt_nxt   = hit_cnt_r;
    acc_cnt_nxt   = acc_cnt_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE_LOG2: bs_nxt = cfg_data[BS_W-1:0];
        CFG_CACHE_SIZE_LOG2: cs_nxt = cfg_data[CS_W-1:0];
        default: begin
        end
      endcase
    end

    if (cmd.clear) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end

    if (cmd.lookup) begin
      idx_nxt = lookup_idx;
      tag_nxt = lookup_tag;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit;
      acc_cnt_nxt   = acc_cnt_r + 1'b1;
      if (hit) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BS_RESET;
      cs_r        <= CS_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
    end else begin
      bs_r        <= bs_nxt;
      cs_r        <= cs_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    tag_r     <= tag_nxt;
    out_hit_r <= out_hit_nxt;
  end

  assign sts.clear_done  = (clr_cnt_r == AW'(LINES - 1));
  assign sts.out_blocked = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_total    = hit_cnt_r;
  assign out_access_total = acc_cnt_r;

endmodule

>>> hdl/direct_mapped_cache_hit_counter.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_counter
// Tag store model of a direct-mapped cache that counts hits and accesses.
// ----------------------------------------------------------------------------
// For each access, the transfer cycle reads the tag and valid RAMs at the
// line index, and the next cycle compares, installs the tag on a miss and
// loads the result register. The compare cycle is held for as long as an
// earlier result waits stalled in the result register. A new access is
// taken while an earlier result still waits in the result register. After
// reset a clearing pass writes every valid bit, one line per cycle, and
// inputs are stalled until the pass ends.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_counter
  import dmchc_pkg::*;
#(
  parameter int LINES_LOG2 = LINES_LOG2_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_access_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [COUNT_W-1:0]    out_hit_total,
  output logic [COUNT_W-1:0]    out_access_total
);

  dmchc_cmd_t cmd;
  dmchc_sts_t sts;

  assign cfg_ready = 1'b1;

  dmchc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  dmchc_dp #(
    .LINES_LOG2 (LINES_LOG2)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_access_address (in_access_address),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_hit_total     (out_hit_total),
    .out_access_total  (out_access_total),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
